@@ rtl/bmd_pkg.sv @@
// ---------------------------------------------------------------------------
// bmd_pkg
// Shared constants, codes and types of the broadcast mailbox device.
// ---------------------------------------------------------------------------
package bmd_pkg;

    localparam int MAX_CLIENTS = 8;
    localparam int STORE_BYTES = 4096;
    localparam int CID_W       = $clog2(MAX_CLIENTS);
    localparam int CNT_W       = CID_W + 1;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int POS_W       = ADDR_W + 1;
    localparam int IRQ_W       = 8;
    localparam int MASK_W      = 8;

    localparam logic [2:0] OP_DREAD  = 3'd0;
    localparam logic [2:0] OP_DWRITE = 3'd1;
    localparam logic [2:0] OP_AREAD  = 3'd2;
    localparam logic [2:0] OP_AWRITE = 3'd3;
    localparam logic [2:0] OP_DIED   = 3'd4;
    localparam logic [2:0] OP_TAKE   = 3'd5;

    localparam logic [3:0] SIZE_BYTE = 4'd1;
    localparam logic [3:0] SIZE_WORD = 4'd4;

    localparam logic [2:0] REG_CLIENT_COUNT = 3'd0;

    localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(2);

    typedef enum logic [2:0] {
        PH_ROLE,
        PH_IDLE,
        PH_WDATA,
        PH_WACK,
        PH_RDATA,
        PH_RACK,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_OPEN_END,
        S_CLOSE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic             load;
        logic             exec;
        logic             walk;
        logic             close;
        logic             resp;
        logic [CID_W-1:0] walk_idx;
    } t_cmd;

    typedef struct packed {
        logic             open_req;
        logic             close_req;
        logic             rr_zero;
        logic             reopen;
        logic [CNT_W-1:0] count;
    } t_stat;

endpackage

@@ rtl/bmd_ctrl.sv @@
// ---------------------------------------------------------------------------
// bmd_ctrl
// Sequencer: accepts a command, runs the evaluate step, walks readers when a
// round opens, closes rounds and issues the result strobe.
// ---------------------------------------------------------------------------
module bmd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bmd_pkg::t_stat i_stat,
    output bmd_pkg::t_cmd  o_cmd
);
    import bmd_pkg::*;

    t_state           r_state, n_state;
    logic [CID_W-1:0] r_walk, n_walk;
    logic             walk_last;
    logic             one_client;

    assign walk_last  = (CNT_W'(r_walk) + CNT_W'(1)) >= i_stat.count;
    assign one_client = i_stat.count <= CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_walk  <= '0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_walk         = r_walk;
        o_cmd          = '0;
        o_cmd.walk_idx = r_walk;
        busy           = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.open_req) begin
                    n_walk  = CID_W'(1);
                    n_state = one_client ? S_OPEN_END : S_WALK;
                end else if (i_stat.close_req) begin
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (walk_last) begin
                    n_state = S_OPEN_END;
                end else begin
                    n_walk = r_walk + CID_W'(1);
                end
            end
            S_OPEN_END: begin
                n_state = i_stat.rr_zero ? S_CLOSE : S_RESP;
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                if (i_stat.reopen) begin
                    n_walk  = CID_W'(1);
                    n_state = one_client ? S_OPEN_END : S_WALK;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                o_cmd.resp = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/bmd_dpath.sv @@
// ---------------------------------------------------------------------------
// bmd_dpath
// Client and round state, byte store and result registers of the mailbox.
// ---------------------------------------------------------------------------
module bmd_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bmd_pkg::t_cmd                i_cmd,
    output bmd_pkg::t_stat               o_stat,
    input  logic                         i_cfg_we,
    input  logic [3:0]                   i_cfg_data,
    output logic [bmd_pkg::CNT_W-1:0]    o_count,
    input  logic [2:0]                   i_op,
    input  logic [bmd_pkg::CID_W-1:0]    i_client_id,
    input  logic [3:0]                   i_access_size,
    input  logic [31:0]                  i_write_data,
    output logic [31:0]                  o_read_data,
    output logic                         o_error,
    output logic                         o_irq_taken,
    output logic [bmd_pkg::MASK_W-1:0]   o_irq_pending_mask,
    output logic                         o_transfer_finished
);
    import bmd_pkg::*;

    // per-client state
    logic             r_alive [MAX_CLIENTS];
    t_phase           r_phase [MAX_CLIENTS];
    logic             r_needs [MAX_CLIENTS];
    logic [IRQ_W-1:0] r_irq   [MAX_CLIENTS];
    logic [POS_W-1:0] r_pos   [MAX_CLIENTS];

    // round state
    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_round_len, n_round_len;
    logic             r_round_open, n_round_open;
    logic [CNT_W-1:0] r_rr, n_rr;
    logic             r_last, n_last;
    logic             r_all_done, n_all_done;
    logic             r_writer_gone, n_writer_gone;
    logic [31:0]      r_announced, n_announced;
    logic [31:0]      r_received, n_received;

    // latched command
    logic [2:0]       r_op;
    logic [CID_W-1:0] r_cid;
    logic [3:0]       r_size;
    logic [31:0]      r_wd;

    // result
    logic [31:0]      r_rd, n_rd;
    logic             r_err, n_err;
    logic             r_taken, n_taken;
    logic             r_rd_mem, n_rd_mem;
    logic             r_mem_ok, n_mem_ok;
    logic [7:0]       r_mem_q;

    logic [7:0]       mem [STORE_BYTES];
    logic             mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;

    logic [CID_W-1:0] idx;
    logic             cur_alive, n_alive;
    t_phase           cur_phase, n_phase;
    logic             cur_needs, n_needs;
    logic [IRQ_W-1:0] cur_irq, n_irq;
    logic [POS_W-1:0] cur_pos, n_pos;
    logic             entry_we;
    logic             open_req, close_req, reopen;
    logic [POS_W-1:0] stored_len;
    logic             writer;
    logic [CNT_W-1:0] init_cnt;
    logic [CNT_W-1:0] cfg_cnt;

    function automatic logic [IRQ_W-1:0] bump(input logic [IRQ_W-1:0] v);
        return (v == {IRQ_W{1'b1}}) ? v : v + IRQ_W'(1);
    endfunction

    assign idx       = i_cmd.walk  ? i_cmd.walk_idx :
                       i_cmd.close ? CID_W'(0) : r_cid;
    assign cur_alive = r_alive[idx];
    assign cur_phase = r_phase[idx];
    assign cur_needs = r_needs[idx];
    assign cur_irq   = r_irq[idx];
    assign cur_pos   = r_pos[idx];
    assign writer    = (r_cid == CID_W'(0));
    assign entry_we  = i_cmd.exec | i_cmd.walk | i_cmd.close;

    assign stored_len = (r_announced < 32'(STORE_BYTES)) ? r_announced[POS_W-1:0]
                                                         : POS_W'(STORE_BYTES);

    assign cfg_cnt  = (CNT_W'(i_cfg_data) > CNT_W'(MAX_CLIENTS)) ? CNT_W'(MAX_CLIENTS)
                                                                 : CNT_W'(i_cfg_data);
    assign init_cnt = !i_rst_n ? RESET_COUNT : cfg_cnt;

    always_comb begin
        n_alive       = cur_alive;
        n_phase       = cur_phase;
        n_needs       = cur_needs;
        n_irq         = cur_irq;
        n_pos         = cur_pos;
        n_round_len   = r_round_len;
        n_round_open  = r_round_open;
        n_rr          = r_rr;
        n_last        = r_last;
        n_all_done    = r_all_done;
        n_writer_gone = r_writer_gone;
        n_announced   = r_announced;
        n_received    = r_received;
        n_rd          = '0;
        n_err         = 1'b0;
        n_taken       = 1'b0;
        n_rd_mem      = 1'b0;
        n_mem_ok      = 1'b0;
        open_req      = 1'b0;
        close_req     = 1'b0;
        reopen        = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = r_received[ADDR_W-1:0];
        mem_raddr     = cur_pos[ADDR_W-1:0];

        if (i_cmd.exec) begin
            if (CNT_W'(r_cid) >= r_count || r_op > OP_TAKE) begin
                n_err = 1'b1;
            end else if (r_op == OP_DIED) begin
                if (cur_alive) begin
                    n_alive = 1'b0;
                    n_irq   = '0;
                    if (!writer) begin
                        if (r_round_open && (cur_needs || cur_phase == PH_RDATA ||
                                             cur_phase == PH_RACK)) begin
                            n_needs   = 1'b0;
                            n_rr      = (r_rr != '0) ? r_rr - CNT_W'(1) : '0;
                            close_req = (n_rr == '0);
                        end
                    end else if (!r_all_done) begin
                        n_writer_gone = 1'b1;
                        if (!r_round_open) begin
                            n_announced  = '0;
                            n_round_len  = '0;
                            n_last       = 1'b1;
                            n_round_open = 1'b1;
                            n_rr         = '0;
                            open_req     = 1'b1;
                        end
                    end
                end
            end else if (!cur_alive) begin
                n_err = 1'b1;
            end else if (r_op == OP_TAKE) begin
                if (cur_irq != '0) begin
                    n_irq   = cur_irq - IRQ_W'(1);
                    n_taken = 1'b1;
                end
            end else begin
                n_err = 1'b1;
                unique case (r_op)
                    OP_DREAD: begin
                        if (cur_phase == PH_ROLE && r_size == SIZE_WORD) begin
                            n_rd    = writer ? 32'd1 : 32'd0;
                            n_phase = PH_IDLE;
                            if (writer) begin
                                n_irq = bump(cur_irq);
                            end
                            n_err = 1'b0;
                        end else if (cur_phase == PH_IDLE && !writer && cur_needs &&
                                     r_size == SIZE_WORD) begin
                            n_rd    = 32'(r_round_len);
                            n_needs = 1'b0;
                            if (r_round_len == '0) begin
                                n_phase = PH_RACK;
                            end else begin
                                n_phase = PH_RDATA;
                                n_pos   = '0;
                            end
                            n_err = 1'b0;
                        end else if (cur_phase == PH_RDATA && r_size == SIZE_BYTE) begin
                            mem_re   = 1'b1;
                            n_rd_mem = 1'b1;
                            n_mem_ok = (cur_pos < POS_W'(STORE_BYTES));
                            n_pos    = cur_pos + POS_W'(1);
                            if (n_pos >= r_round_len) begin
                                n_phase = PH_RACK;
                            end
                            n_err = 1'b0;
                        end
                    end
                    OP_DWRITE: begin
                        if (cur_phase == PH_IDLE && writer && !r_round_open &&
                            r_size == SIZE_WORD) begin
                            n_announced = r_wd;
                            n_received  = '0;
                            if (r_wd == '0) begin
                                n_round_len  = '0;
                                n_last       = 1'b1;
                                n_round_open = 1'b1;
                                n_rr         = '0;
                                open_req     = 1'b1;
                                n_phase      = PH_WACK;
                            end else begin
                                n_phase = PH_WDATA;
                            end
                            n_err = 1'b0;
                        end else if (cur_phase == PH_WDATA && r_size == SIZE_BYTE) begin
                            mem_we     = (r_received < 32'(STORE_BYTES));
                            n_received = r_received + 32'd1;
                            if (n_received == r_announced) begin
                                n_round_len  = stored_len;
                                n_last       = 1'b0;
                                n_round_open = 1'b1;
                                n_rr         = '0;
                                open_req     = 1'b1;
                                n_phase      = PH_WACK;
                            end
                            n_err = 1'b0;
                        end
                    end
                    OP_AREAD: begin
                        if (cur_phase == PH_WACK && r_size == SIZE_WORD) begin
                            n_rd    = 32'(stored_len);
                            n_phase = (r_announced == '0) ? PH_DONE : PH_IDLE;
                            n_err   = 1'b0;
                        end
                    end
                    OP_AWRITE: begin
                        if (cur_phase == PH_RACK && r_size == SIZE_WORD &&
                            r_wd == 32'(r_round_len)) begin
                            n_phase   = r_last ? PH_DONE : PH_IDLE;
                            n_rr      = (r_rr != '0) ? r_rr - CNT_W'(1) : '0;
                            close_req = (n_rr == '0);
                            n_err     = 1'b0;
                        end
                    end
                    default: n_err = 1'b1;
                endcase
            end
        end

        // one reader per cycle while a round opens
        if (i_cmd.walk) begin
            if (cur_alive && cur_phase != PH_DONE) begin
                n_needs = 1'b1;
                n_irq   = bump(cur_irq);
                n_rr    = r_rr + CNT_W'(1);
            end
        end

        // index is the writer here
        if (i_cmd.close) begin
            n_round_open = 1'b0;
            if (r_last) begin
                n_all_done = 1'b1;
            end else if (!r_writer_gone && cur_alive) begin
                n_irq = bump(cur_irq);
            end else if (!r_all_done) begin
                n_announced  = '0;
                n_round_len  = '0;
                n_last       = 1'b1;
                n_round_open = 1'b1;
                n_rr         = '0;
                reopen       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_count       <= init_cnt;
            r_round_len   <= '0;
            r_round_open  <= 1'b0;
            r_rr          <= '0;
            r_last        <= 1'b0;
            r_all_done    <= 1'b0;
            r_writer_gone <= 1'b0;
            r_announced   <= '0;
            r_received    <= '0;
            for (int i = 0; i < MAX_CLIENTS; i++) begin
                r_alive[i] <= (CNT_W'(i) < init_cnt);
                r_phase[i] <= PH_ROLE;
                r_needs[i] <= 1'b0;
                r_irq[i]   <= (CNT_W'(i) < init_cnt) ? IRQ_W'(1) : '0;
                r_pos[i]   <= '0;
            end
        end else begin
            r_round_len   <= n_round_len;
            r_round_open  <= n_round_open;
            r_rr          <= n_rr;
            r_last        <= n_last;
            r_all_done    <= n_all_done;
            r_writer_gone <= n_writer_gone;
            r_announced   <= n_announced;
            r_received    <= n_received;
            if (entry_we) begin
                r_alive[idx] <= n_alive;
                r_phase[idx] <= n_phase;
                r_needs[idx] <= n_needs;
                r_irq[idx]   <= n_irq;
                r_pos[idx]   <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_cid  <= i_client_id;
            r_size <= i_access_size;
            r_wd   <= i_write_data;
        end
        if (i_cmd.exec) begin
            r_rd     <= n_rd;
            r_err    <= n_err;
            r_taken  <= n_taken;
            r_rd_mem <= n_rd_mem;
            r_mem_ok <= n_mem_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= r_wd[7:0];
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

    always_comb begin
        o_irq_pending_mask = '0;
        for (int i = 0; i < MASK_W; i++) begin
            o_irq_pending_mask[i] = (CNT_W'(i) < r_count) && (r_irq[i] != '0);
        end
    end

    assign o_read_data         = r_rd_mem ? (r_mem_ok ? 32'(r_mem_q) : '0) : r_rd;
    assign o_error             = r_err;
    assign o_irq_taken         = r_taken;
    assign o_transfer_finished = r_all_done;
    assign o_count             = r_count;

    assign o_stat.open_req  = open_req;
    assign o_stat.close_req = close_req;
    assign o_stat.rr_zero   = (r_rr == '0);
    assign o_stat.reopen    = reopen;
    assign o_stat.count     = r_count;

endmodule

@@ rtl/broadcast_mailbox_device.sv @@
// ---------------------------------------------------------------------------
// broadcast_mailbox_device
// One-writer, many-reader broadcast mailbox with per-client interrupts.
// ---------------------------------------------------------------------------
//  channel   | handshake                    | payload
//  command   | start, busy                  | i_op, i_client_id, i_access_size,
//            |                              | i_write_data
//  result    | o_done (one-cycle strobe)    | o_read_data, o_error, o_irq_taken,
//            |                              | o_irq_pending_mask, o_transfer_finished
//  config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// a beat runs latch, evaluate and result steps; opening a round adds a walk over
// the reader slots and an open-end step, and closing it a close step, which may
// reopen a final round after an ack closes one; the walk visits the client slots
// one at a time through one shared state port.
// synchronous reset restores client_count 2; the result cannot be stalled.
// ---------------------------------------------------------------------------
module broadcast_mailbox_device (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 i_op,
    input  logic [bmd_pkg::CID_W-1:0]  i_client_id,
    input  logic [3:0]                 i_access_size,
    input  logic [31:0]                i_write_data,
    output logic                       o_done,
    output logic [31:0]                o_read_data,
    output logic                       o_error,
    output logic                       o_irq_taken,
    output logic [bmd_pkg::MASK_W-1:0] o_irq_pending_mask,
    output logic                       o_transfer_finished,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bmd_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    logic             cfg_we;
    logic [CNT_W-1:0] count;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(count) : '0;

    bmd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bmd_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_we            (cfg_we),
        .i_cfg_data          (pwdata[3:0]),
        .o_count             (count),
        .i_op                (i_op),
        .i_client_id         (i_client_id),
        .i_access_size       (i_access_size),
        .i_write_data        (i_write_data),
        .o_read_data         (o_read_data),
        .o_error             (o_error),
        .o_irq_taken         (o_irq_taken),
        .o_irq_pending_mask  (o_irq_pending_mask),
        .o_transfer_finished (o_transfer_finished)
    );

    assign o_done = cmd.resp;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after result strobe");

    a_taken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_irq_taken |-> !o_error)
        else $error("interrupt taken on an error result");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_transfer_finished && !cfg_we) |=> o_transfer_finished)
        else $error("transfer finished dropped without reconfiguration");

endmodule
